// ===== hw/rtl/asmq_pkg.sv =====
package asmq_pkg;

  // Reading codes, shared by sensor inputs and held states
  localparam logic [1:0] RdClear  = 2'd0;
  localparam logic [1:0] RdTrig   = 2'd1;
  localparam logic [1:0] RdUnread = 2'd2;

  // Request action codes
  localparam logic [2:0] ActSample   = 3'd0;
  localparam logic [2:0] ActLimitFb  = 3'd1;
  localparam logic [2:0] ActSetPend  = 3'd2;
  localparam logic [2:0] ActReplied  = 3'd3;
  localparam logic [2:0] ActTick     = 3'd4;
  localparam logic [2:0] ActReset    = 3'd5;

  // Configuration register indexes
  localparam logic [1:0] CfgStaleTicks      = 2'd0;
  localparam logic [1:0] CfgIdleNeeded      = 2'd1;
  localparam logic [1:0] CfgMotionNeeded    = 2'd2;
  localparam logic [1:0] CfgDropoutsAllowed = 2'd3;

  localparam int unsigned CfgIdxWidth  = 2;
  localparam int unsigned CfgDataWidth = 16;

  // Configuration reset values
  localparam logic [15:0] StaleTicksRst      = 16'd30000;
  localparam logic [3:0]  IdleNeededRst      = 4'd2;
  localparam logic [3:0]  MotionNeededRst    = 4'd2;
  localparam logic [2:0]  DropoutsAllowedRst = 3'd1;

  typedef struct packed {
    logic [2:0] action;
    logic [1:0] low_reading;
    logic [1:0] org_reading;
    logic [1:0] high_reading;
    logic [1:0] motion_reading;
    logic [1:0] limit_reading;
    logic       high_side;
    logic       pending;
    logic [7:0] activity_tag;
  } req_t;

  typedef struct packed {
    logic [1:0] low_state;
    logic [1:0] org_state;
    logic [1:0] high_state;
    logic [1:0] motion_state;
    logic       axis_moving;
    logic       command_busy;
    logic       reply_seen;
    logic       is_stale;
    logic       sensors_changed;
    logic       command_done;
    logic [7:0] current_activity;
  } rsp_t;

  typedef struct packed {
    logic stale;
    logic moving;
    logic pending;
    logic replied;
    logic saw_motion;
  } flags_t;

  localparam flags_t FlagsRst = '{stale: 1'b1, moving: 1'b0, pending: 1'b0,
                                  replied: 1'b0, saw_motion: 1'b0};

  // Map the unused code three to unreadable
  function automatic logic [1:0] norm_reading(input logic [1:0] r);
    return (r == 2'd3) ? RdUnread : r;
  endfunction

  function automatic logic [3:0] sat_inc4(input logic [3:0] v);
    return (v == 4'hF) ? v : v + 4'd1;
  endfunction

endpackage

// ===== hw/rtl/axis_sensor_motion_qualifier.sv =====
// Axis sensor motion qualifier.
// Input channel: in_valid_i / in_stall_o carry one request (req_t) per cycle:
// a sensor sample, limit feedback, set pending, rig reply, tick or reset.
// Output channel: out_valid_o / out_stall_i carry one result (rsp_t) per
// request, showing the held sensor states and status after that request.
// The result is registered: it appears in the output register on the
// clock after the request is taken. Throughput is one request per cycle;
// the whole update is a single pass of flag and 4/16-bit counter logic
// from the tracking registers into the result register.
// When the receiver stalls, the result register holds its content and
// in_stall_o rises only while that register is full and stalled, so a new
// request is taken in the same cycle the old result leaves.
// Configuration: cfg_valid_i / cfg_ready_o with a register index and data;
// ready is always high. Write only while no request is in flight.
// Reset (rst_ni low) restores default configuration, sets all held sensor
// states to unreadable, marks the axis stale and empties the output.
module axis_sensor_motion_qualifier
  import asmq_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  req_t                    in_data_i,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output rsp_t                    out_data_o,
  input  logic                    cfg_valid_i,
  output logic                    cfg_ready_o,
  input  logic [CfgIdxWidth-1:0]  cfg_index_i,
  input  logic [CfgDataWidth-1:0] cfg_data_i
);

  logic [15:0] stale_ticks_q;
  logic [3:0]  idle_needed_q, motion_needed_q;
  logic [2:0]  drops_allowed_q;

  logic [1:0]  low_q, org_q, high_q, motion_q;
  logic [1:0]  low_d, org_d, high_d, motion_d;
  logic [3:0]  drop_q [3];
  logic [3:0]  drop_d [3];
  logic [3:0]  idle_q, idle_d, mstreak_q, mstreak_d;
  flags_t      flags_q, flags_d;
  logic [15:0] elapsed_q, elapsed_d;
  logic [7:0]  act_q, act_d;

  logic        out_valid_q;
  rsp_t        out_q;

  logic        accept;
  logic        changed, done;
  logic [1:0]  mv, lim;
  logic [1:0]  hv [3];
  logic [1:0]  rd_in [3];
  logic [1:0]  rd_prev [3];

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = out_valid_q & out_stall_i;
  assign accept      = in_valid_i & ~in_stall_o;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stale_ticks_q   <= StaleTicksRst;
      idle_needed_q   <= IdleNeededRst;
      motion_needed_q <= MotionNeededRst;
      drops_allowed_q <= DropoutsAllowedRst;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CfgStaleTicks:      stale_ticks_q   <= cfg_data_i;
        CfgIdleNeeded:      idle_needed_q   <= cfg_data_i[3:0];
        CfgMotionNeeded:    motion_needed_q <= cfg_data_i[3:0];
        CfgDropoutsAllowed: drops_allowed_q <= cfg_data_i[2:0];
        default: ;
      endcase
    end
  end

  assign rd_in[0]   = norm_reading(in_data_i.low_reading);
  assign rd_in[1]   = norm_reading(in_data_i.org_reading);
  assign rd_in[2]   = norm_reading(in_data_i.high_reading);
  assign rd_prev[0] = low_q;
  assign rd_prev[1] = org_q;
  assign rd_prev[2] = high_q;
  assign mv         = norm_reading(in_data_i.motion_reading);
  assign lim        = norm_reading(in_data_i.limit_reading);

  // Bridge dropouts: hold the last good value until the count runs past the limit
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      drop_d[i] = drop_q[i];
      hv[i]     = rd_in[i];
      if (rd_in[i] != RdUnread) begin
        drop_d[i] = 4'd0;
      end else if (rd_prev[i] == RdUnread) begin
        hv[i] = RdUnread;
      end else begin
        drop_d[i] = sat_inc4(drop_q[i]);
        hv[i]     = (drop_d[i] > {1'b0, drops_allowed_q}) ? RdUnread : rd_prev[i];
      end
    end
  end

  always_comb begin
    low_d     = low_q;
    org_d     = org_q;
    high_d    = high_q;
    motion_d  = motion_q;
    idle_d    = idle_q;
    mstreak_d = mstreak_q;
    flags_d   = flags_q;
    elapsed_d = elapsed_q;
    act_d     = act_q;
    changed   = 1'b0;
    done      = 1'b0;
    unique case (in_data_i.action)
      ActSample: begin
        low_d    = hv[0];
        org_d    = hv[1];
        high_d   = hv[2];
        motion_d = mv;
        changed  = (hv[0] != low_q) || (hv[1] != org_q) || (hv[2] != high_q) ||
                   (mv != motion_q);
        if (mv == RdClear) begin
          idle_d    = sat_inc4(idle_q);
          mstreak_d = 4'd0;
        end else if (mv == RdTrig) begin
          mstreak_d = sat_inc4(mstreak_q);
          idle_d    = 4'd0;
        end else begin
          idle_d    = 4'd0;
          mstreak_d = 4'd0;
        end
        if (mv == RdTrig && (flags_q.pending || mstreak_d >= motion_needed_q)) begin
          flags_d.saw_motion = 1'b1;
          flags_d.moving     = 1'b1;
        end else if (flags_q.moving && idle_d >= idle_needed_q) begin
          flags_d.moving = 1'b0;
        end
        flags_d.stale = 1'b0;
        elapsed_d     = 16'd0;
        if (flags_d.pending && flags_d.replied && !flags_d.moving &&
            idle_d >= idle_needed_q) begin
          flags_d.pending = 1'b0;
          act_d           = 8'd0;
          done            = 1'b1;
        end
      end
      ActLimitFb: begin
        if (in_data_i.high_side) begin
          high_d  = lim;
          changed = (lim != high_q);
        end else begin
          low_d   = lim;
          changed = (lim != low_q);
        end
        flags_d.stale = 1'b0;
        elapsed_d     = 16'd0;
      end
      ActSetPend: begin
        if (!(flags_q.pending == in_data_i.pending && act_q == in_data_i.activity_tag)) begin
          act_d = in_data_i.activity_tag;
          if (in_data_i.pending) begin
            flags_d.pending    = 1'b1;
            flags_d.saw_motion = 1'b0;
            flags_d.replied    = 1'b0;
            idle_d             = 4'd0;
            mstreak_d          = 4'd0;
          end else begin
            flags_d.pending = 1'b0;
          end
        end
      end
      ActReplied: begin
        if (flags_q.pending && !flags_q.replied) begin
          flags_d.replied = 1'b1;
          if (!flags_q.saw_motion) begin
            idle_d = 4'd0;
          end
          if (!flags_q.moving && idle_d >= idle_needed_q) begin
            flags_d.pending = 1'b0;
            act_d           = 8'd0;
            done            = 1'b1;
          end
        end
      end
      ActTick: begin
        elapsed_d = (elapsed_q == 16'hFFFF) ? elapsed_q : elapsed_q + 16'd1;
        if (!flags_q.stale && elapsed_d >= stale_ticks_q) begin
          idle_d    = 4'd0;
          mstreak_d = 4'd0;
          flags_d   = FlagsRst;
          act_d     = 8'd0;
        end
      end
      ActReset: begin
        changed   = (low_q != RdUnread) || (org_q != RdUnread) ||
                    (high_q != RdUnread) || (motion_q != RdUnread);
        low_d     = RdUnread;
        org_d     = RdUnread;
        high_d    = RdUnread;
        motion_d  = RdUnread;
        idle_d    = 4'd0;
        mstreak_d = 4'd0;
        flags_d   = FlagsRst;
        act_d     = 8'd0;
        elapsed_d = 16'd0;
      end
      default: ;
    endcase
  end

  // Dropout counts move only on samples and get cleared by timeout and reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 3; i++) begin
        drop_q[i] <= 4'd0;
      end
    end else if (accept) begin
      for (int i = 0; i < 3; i++) begin
        if (in_data_i.action == ActSample) begin
          drop_q[i] <= drop_d[i];
        end else if (in_data_i.action == ActReset ||
                     (in_data_i.action == ActTick && flags_q.stale == 1'b0 &&
                      elapsed_d >= stale_ticks_q)) begin
          drop_q[i] <= 4'd0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      low_q     <= RdUnread;
      org_q     <= RdUnread;
      high_q    <= RdUnread;
      motion_q  <= RdUnread;
      idle_q    <= 4'd0;
      mstreak_q <= 4'd0;
      flags_q   <= FlagsRst;
      elapsed_q <= 16'd0;
      act_q     <= 8'd0;
    end else if (accept) begin
      low_q     <= low_d;
      org_q     <= org_d;
      high_q    <= high_d;
      motion_q  <= motion_d;
      idle_q    <= idle_d;
      mstreak_q <= mstreak_d;
      flags_q   <= flags_d;
      elapsed_q <= elapsed_d;
      act_q     <= act_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_q.low_state        <= low_d;
      out_q.org_state        <= org_d;
      out_q.high_state       <= high_d;
      out_q.motion_state     <= motion_d;
      out_q.axis_moving      <= flags_d.moving;
      out_q.command_busy     <= flags_d.pending;
      out_q.reply_seen       <= flags_d.replied;
      out_q.is_stale         <= flags_d.stale;
      out_q.sensors_changed  <= changed;
      out_q.command_done     <= done;
      out_q.current_activity <= act_d;
    end
  end

endmodule
